### rtl/od_pkg.sv
// Shared types and codes of the object dictionary table.
package od_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_READ_WO   = 3'd2,
    STAT_WRITE_RO  = 3'd3,
    STAT_FULL      = 3'd4
  } status_t;

  localparam logic [1:0] ACC_RO    = 2'd0;
  localparam logic [1:0] ACC_WO    = 2'd1;
  localparam logic [1:0] ACC_RW    = 2'd2;
  localparam logic [1:0] ACC_CONST = 2'd3;

  localparam int KEY_W  = 24;
  localparam int ATTR_W = 18;
  localparam int ENTRY_W = KEY_W + ATTR_W;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] obj_index;
    logic [7:0]  obj_sub_index;
    logic [31:0] value;
    logic [1:0]  access_kind_in;
    logic [15:0] data_kind_in;
  } req_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_value;
    logic [1:0]  access_kind;
    logic [15:0] data_kind;
    logic [7:0]  bit_length;
  } rsp_word_t;

endpackage

### rtl/object_dictionary_table.sv
// Object dictionary table: entry memories, linear search sequencer and reply register.
// A load or an unused command goes from the idle state to the reply state, and from there
// reaches the rsp register once that register is not held by a stall. A read or write runs
// two linear searches over the loaded entries, one entry per cycle, then ends in the reply state.
// One word at a time: the next is taken the cycle after the reply is registered, even if it waits.
// Reset (rst, synchronous) clears the entry count and the control state; the RAMs keep
// their contents, and only entries below the count are ever searched.
module object_dictionary_table
  import od_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_word_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_word_t rsp
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_SCAN_OBJ  = 6'b000010,
    S_OBJ_VAL   = 6'b000100,
    S_SCAN_TYPE = 6'b001000,
    S_TYPE_VAL  = 6'b010000,
    S_REPLY     = 6'b100000
  } state_t;

  state_t state, state_next;

  // Entry count and the scan pointers. ptr is the next slot to read; cmp_addr is the
  // slot whose entry sits on the RAM output when cmp_vld is set.
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic          cmp_vld;
  logic [AW-1:0] cmp_addr;

  // Captured request and what the object search found.
  req_word_t          req_q;
  logic [KEY_W-1:0]   search_key;
  logic [AW-1:0]      slot;
  logic [1:0]         obj_acc;
  logic [15:0]        obj_dk;
  logic [31:0]        obj_val;
  rsp_word_t          res;

  logic               req_take;
  logic               load_ok;
  logic               full;

  // Memory ports.
  logic [ENTRY_W-1:0] ent_rdata;
  logic [31:0]        val_rdata;
  logic               val_we;
  logic [AW-1:0]      val_waddr;
  logic [31:0]        val_wdata;
  logic               wb_en;

  logic               hit;
  logic               more;
  logic [7:0]         type_bits;
  rsp_word_t          fin;

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign full      = (count == CW'(MAX_ENTRIES));
  assign load_ok   = req_take && (req.cmd == CMD_LOAD) && !full;

  // Key and attributes share one entry RAM; the value lives in a second RAM so that
  // a write can update it without touching the key.
  od_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (load_ok),
    .waddr (count[AW-1:0]),
    .wdata ({req.obj_index, req.obj_sub_index, req.access_kind_in, req.data_kind_in}),
    .raddr (ptr[AW-1:0]),
    .rdata (ent_rdata)
  );

  od_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (cmp_addr),
    .rdata (val_rdata)
  );

  // A write-back happens only at the very end of a write, after its value reads, so
  // no read of the same slot can overlap it.
  assign val_we    = load_ok || wb_en;
  assign val_waddr = load_ok ? count[AW-1:0] : slot;
  assign val_wdata = load_ok ? req.value : req_q.value;

  assign hit  = cmp_vld && (ent_rdata[ENTRY_W-1:ATTR_W] == search_key);
  assign more = (ptr < count);

  // The type length saturates at 255 and is zero when no type entry exists.
  always_comb begin
    if (state == S_TYPE_VAL) begin
      type_bits = (val_rdata > 32'd255) ? 8'd255 : val_rdata[7:0];
    end else begin
      type_bits = 8'd0;
    end
  end

  // Final reply of a read or write once the type search is over.
  always_comb begin
    fin             = '0;
    fin.access_kind = obj_acc;
    fin.data_kind   = obj_dk;
    fin.bit_length  = type_bits;
    fin.status      = STAT_OK;
    wb_en           = 1'b0;
    if (req_q.cmd == CMD_READ) begin
      if (obj_acc == ACC_WO) begin
        fin.status = STAT_READ_WO;
      end else begin
        fin.read_value = obj_val;
      end
    end else begin
      if ((obj_acc == ACC_WO) || (obj_acc == ACC_RW)) begin
        wb_en = (state == S_TYPE_VAL) || ((state == S_SCAN_TYPE) && !hit && !more && !cmp_vld);
      end else begin
        fin.status = STAT_WRITE_RO;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_take) begin
          state_next = (req.cmd == CMD_READ || req.cmd == CMD_WRITE) ? S_SCAN_OBJ : S_REPLY;
        end
      end
      S_SCAN_OBJ: begin
        if (hit) begin
          state_next = S_OBJ_VAL;
        end else if (!more && !cmp_vld) begin
          state_next = S_REPLY;
        end
      end
      S_OBJ_VAL: begin
        state_next = S_SCAN_TYPE;
      end
      S_SCAN_TYPE: begin
        if (hit) begin
          state_next = S_TYPE_VAL;
        end else if (!more && !cmp_vld) begin
          state_next = S_REPLY;
        end
      end
      S_TYPE_VAL: begin
        state_next = S_REPLY;
      end
      S_REPLY: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ptr       <= '0;
      cmp_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_ok) begin
        count <= count + CW'(1);
      end

      // Shared scan step: one RAM read issued and one compare made per cycle.
      if (state == S_SCAN_OBJ || state == S_SCAN_TYPE) begin
        if (hit) begin
          cmp_vld <= 1'b0;
        end else if (more) begin
          ptr     <= ptr + CW'(1);
          cmp_vld <= 1'b1;
        end else begin
          cmp_vld <= 1'b0;
        end
      end else begin
        ptr     <= '0;
        cmp_vld <= 1'b0;
      end

      if (state == S_REPLY && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_take) begin
      req_q      <= req;
      search_key <= {req.obj_index, req.obj_sub_index};
      if (req.cmd == CMD_LOAD && full) begin
        res <= '{status: STAT_FULL, default: '0};
      end else begin
        res <= '0;
      end
    end

    if ((state == S_SCAN_OBJ || state == S_SCAN_TYPE) && !hit && more) begin
      cmp_addr <= ptr[AW-1:0];
    end

    if (state == S_SCAN_OBJ) begin
      if (hit) begin
        slot    <= cmp_addr;
        obj_acc <= ent_rdata[ATTR_W-1:16];
        obj_dk  <= ent_rdata[15:0];
      end else if (!more && !cmp_vld) begin
        res <= '{status: STAT_NOT_FOUND, default: '0};
      end
    end

    if (state == S_OBJ_VAL) begin
      obj_val    <= val_rdata;
      search_key <= {obj_dk, 8'h00};
    end

    if ((state == S_SCAN_TYPE && !hit && !more && !cmp_vld) || state == S_TYPE_VAL) begin
      res <= fin;
    end

    if (state == S_REPLY && (!rsp_valid || !rsp_stall)) begin
      rsp <= res;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_load_counts: assert property (@(posedge clk) disable iff (rst)
    load_ok |=> (count == $past(count) + CW'(1)))
    else $error("load did not advance the entry count");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    cmp_vld |-> (CW'(cmp_addr) < count))
    else $error("compare on an entry that was never loaded");

  a_wo_no_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == STAT_READ_WO) |-> (rsp.read_value == 32'd0))
    else $error("write-only entry returned data");

  a_wb_in_type_phase: assert property (@(posedge clk) disable iff (rst)
    wb_en |-> (req_q.cmd == CMD_WRITE && (state == S_TYPE_VAL || state == S_SCAN_TYPE)))
    else $error("value write-back outside a write");

endmodule

### rtl/od_ram.sv
// Generic single-write, single-read RAM with registered read data.
module od_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/od_table_checker.sv
// Checker for the object dictionary table: predicts each response word and compares it.
module od_table_checker
  import od_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_stall,
  input  req_word_t req,
  input  logic      rsp_valid,
  input  logic      rsp_stall,
  input  rsp_word_t rsp,
  output int        mismatches,
  output int        pending,
  output int        replies_checked
);

  // Shadow copy of the dictionary: keys, attributes and data of loaded entries.
  logic [23:0] entry_key  [DEPTH];
  logic [1:0]  entry_acc  [DEPTH];
  logic [15:0] entry_type [DEPTH];
  logic [31:0] entry_data [DEPTH];
  int          entry_total = 0;

  rsp_word_t   expected_replies [$];
  int          error_total = 0;
  int          checked_total = 0;

  // First loaded entry with this key, or -1.
  function automatic int find_entry(logic [23:0] key);
    for (int i = 0; i < entry_total; i++) begin
      if (entry_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Works out the response to one request word and applies its effect on the table.
  function automatic rsp_word_t dictionary_reply(req_word_t w);
    rsp_word_t   r;
    int          slot;
    int          type_slot;
    logic [23:0] key;
    r = '0;
    key = {w.obj_index, w.obj_sub_index};
    case (w.cmd)
      CMD_LOAD: begin
        if (entry_total >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          entry_key[entry_total]  = key;
          entry_acc[entry_total]  = w.access_kind_in;
          entry_type[entry_total] = w.data_kind_in;
          entry_data[entry_total] = w.value;
          entry_total++;
        end
      end
      CMD_READ, CMD_WRITE: begin
        slot = find_entry(key);
        if (slot < 0) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          r.access_kind = entry_acc[slot];
          r.data_kind = entry_type[slot];
          type_slot = find_entry({entry_type[slot], 8'h00});
          if (type_slot >= 0) begin
            r.bit_length = (entry_data[type_slot] > 32'd255) ? 8'hFF : entry_data[type_slot][7:0];
          end
          if (w.cmd == CMD_READ) begin
            if (entry_acc[slot] == ACC_WO) r.status = STAT_READ_WO;
            else r.read_value = entry_data[slot];
          end else begin
            if (entry_acc[slot] == ACC_WO || entry_acc[slot] == ACC_RW) begin
              entry_data[slot] = w.value;
            end else begin
              r.status = STAT_WRITE_RO;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_total++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    rsp_word_t want;
    if (rst) begin
      entry_total = 0;
      expected_replies.delete();
    end else begin
      // A response can never belong to a request taken at the same edge, so pop first.
      if (rsp_valid && !rsp_stall) begin
        if (expected_replies.size() == 0) begin
          error_total++;
          $display("%0t: response word %h arrived with nothing expected", $time, rsp);
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 32'(want.status), 32'(rsp.status));
          check_field("read_value", want.read_value, rsp.read_value);
          check_field("access_kind", 32'(want.access_kind), 32'(rsp.access_kind));
          check_field("data_kind", 32'(want.data_kind), 32'(rsp.data_kind));
          check_field("bit_length", 32'(want.bit_length), 32'(rsp.bit_length));
          checked_total++;
        end
      end
      if (req_valid && !req_stall) expected_replies.push_back(dictionary_reply(req));
    end
    mismatches <= error_total;
    pending <= expected_replies.size();
    replies_checked <= checked_total;
  end

endmodule

### tb/testbench.sv
// Top of the object dictionary table testbench: clock, reset, stimulus and verdict.
module testbench
  import od_pkg::*;
();

  localparam int TABLE_DEPTH = 64;
  // The watchdog limit leaves ample margin over the slowest correct run.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_WORDS = 900;
  // A read or write walks the table twice, so this covers one full search after the drain.
  localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 30;

  logic      clk = 1'b0;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  req_word_t req;
  logic      rsp_valid;
  logic      rsp_stall;
  rsp_word_t rsp;

  int mismatches;
  int pending;
  int replies_checked;

  // While quiet is set, neither the sender nor the receiver inserts any idle cycles.
  bit quiet = 1'b0;
  int cycle_count = 0;

  // Keys that were loaded into a free slot; reads and writes mostly aim at these so that
  // they get past the search and exercise the access rules.
  logic [23:0] known_keys [$];
  int          loads_sent = 0;
  int          loads_refused = 0;
  int          words_sent = 0;

  always #5 clk = ~clk;

  object_dictionary_table #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  od_table_checker #(
    .DEPTH(TABLE_DEPTH)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .mismatches(mismatches),
    .pending(pending),
    .replies_checked(replies_checked)
  );

  // The receiver stalls on about one cycle in five, except during the quiet stretch.
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 20);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding.", cycle_count, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic req_word_t make_word(cmd_t cmd, logic [15:0] idx, logic [7:0] sub,
                                          logic [31:0] val, logic [1:0] acc,
                                          logic [15:0] kind);
    req_word_t w;
    w.cmd = cmd;
    w.obj_index = idx;
    w.obj_sub_index = sub;
    w.value = val;
    w.access_kind_in = acc;
    w.data_kind_in = kind;
    return w;
  endfunction

  // Builds one random request word. Loads favor a small set of type entries (index 1 to 8,
  // sub-index 0) and a small set of object indexes, so that duplicates and type lookups occur
  // often. Type codes 9 and 10 are never loaded as type entries and give a zero bit length.
  function automatic req_word_t random_word();
    req_word_t   w;
    int          pick;
    int          load_share;
    logic [23:0] key;
    w.value = $urandom();
    w.access_kind_in = 2'($urandom_range(0, 3));
    w.data_kind_in = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(1, 10))
                                                : 16'($urandom());
    load_share = (loads_sent < TABLE_DEPTH) ? 15 : 8;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      w.cmd = CMD_NONE;
      key = 24'($urandom());
    end else if (pick < 2 + load_share) begin
      w.cmd = CMD_LOAD;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        key = {16'($urandom_range(1, 8)), 8'h00};
        // Type entries mostly carry sensible bit counts, some beyond 255 to saturate.
        if ($urandom_range(0, 1) != 0) w.value = $urandom_range(0, 300);
      end else if (pick < 80) begin
        key = {16'h1000 + 16'($urandom_range(0, 7)), 8'($urandom_range(0, 3))};
      end else begin
        key = 24'($urandom());
      end
    end else begin
      w.cmd = ($urandom_range(0, 1) != 0) ? CMD_READ : CMD_WRITE;
      if (known_keys.size() != 0 && $urandom_range(0, 99) < 80) begin
        key = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else if ($urandom_range(0, 1) != 0) begin
        key = {16'h1000 + 16'($urandom_range(0, 7)), 8'($urandom_range(0, 3))};
      end else begin
        key = 24'($urandom());
      end
    end
    {w.obj_index, w.obj_sub_index} = key;
    return w;
  endfunction

  // Presents one word, possibly after a short gap, and returns at the falling edge after it
  // was taken. When no gap is drawn, valid stays high and only the payload changes.
  task automatic send_word(req_word_t w);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (req_stall);
    words_sent++;
    if (w.cmd == CMD_LOAD) begin
      if (loads_sent < TABLE_DEPTH) known_keys.push_back({w.obj_index, w.obj_sub_index});
      else loads_refused++;
      loads_sent++;
    end
    @(negedge clk);
  endtask

  // Holds the sender off until every expected response has been seen.
  task automatic drain();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Searches on the empty table and the unused command come first.
    send_word(make_word(CMD_READ, 16'h1000, 8'h01, 32'h0, ACC_RO, 16'h0000));
    send_word(make_word(CMD_WRITE, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, ACC_CONST, 16'hFFFF));
    send_word(make_word(CMD_NONE, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, ACC_CONST, 16'hFFFF));
    // Type entries: one of 32 bits that describes itself, one saturating, one at key zero,
    // and a read-write one whose bit count is changed later.
    send_word(make_word(CMD_LOAD, 16'h0007, 8'h00, 32'd32, ACC_RO, 16'h0007));
    send_word(make_word(CMD_LOAD, 16'hFFFF, 8'h00, 32'hFFFF_FFFF, ACC_CONST, 16'hFFFF));
    send_word(make_word(CMD_LOAD, 16'h0000, 8'h00, 32'h0, ACC_RO, 16'h0000));
    send_word(make_word(CMD_LOAD, 16'h0008, 8'h00, 32'd300, ACC_RW, 16'h0007));
    // Object entries, including a duplicate key that must stay hidden behind the first one.
    send_word(make_word(CMD_LOAD, 16'h1000, 8'h01, 32'hDEAD_BEEF, ACC_RW, 16'h0008));
    send_word(make_word(CMD_LOAD, 16'h1000, 8'h01, 32'h1234_5678, ACC_WO, 16'h0007));
    send_word(make_word(CMD_LOAD, 16'h2000, 8'hFF, 32'h0, ACC_WO, 16'hFFFF));
    send_word(make_word(CMD_LOAD, 16'h3000, 8'h00, 32'd55, ACC_CONST, 16'h1234));
    // The read sees the saturated type length; after the type entry is rewritten it sees 16.
    send_word(make_word(CMD_READ, 16'h1000, 8'h01, 32'h0, ACC_RO, 16'h0000));
    send_word(make_word(CMD_WRITE, 16'h0008, 8'h00, 32'd16, ACC_RO, 16'h0000));
    send_word(make_word(CMD_READ, 16'h1000, 8'h01, 32'h0, ACC_RO, 16'h0000));
    send_word(make_word(CMD_WRITE, 16'h1000, 8'h01, 32'hFFFF_FFFF, ACC_RO, 16'h0000));
    send_word(make_word(CMD_READ, 16'h1000, 8'h01, 32'h0, ACC_RO, 16'h0000));
    // Write-only entry: a read is refused, a write is stored.
    send_word(make_word(CMD_READ, 16'h2000, 8'hFF, 32'h0, ACC_RO, 16'h0000));
    send_word(make_word(CMD_WRITE, 16'h2000, 8'hFF, 32'h0000_A5A5, ACC_RO, 16'h0000));
    // Writes to read-only and constant entries are refused and leave the data alone.
    send_word(make_word(CMD_WRITE, 16'h0007, 8'h00, 32'd99, ACC_RO, 16'h0000));
    send_word(make_word(CMD_WRITE, 16'h3000, 8'h00, 32'd77, ACC_RO, 16'h0000));
    send_word(make_word(CMD_READ, 16'h3000, 8'h00, 32'h0, ACC_RO, 16'h0000));
    send_word(make_word(CMD_READ, 16'h0000, 8'h00, 32'h0, ACC_RO, 16'h0000));
    send_word(make_word(CMD_READ, 16'hFFFF, 8'h00, 32'h0, ACC_RO, 16'h0000));
    // Same index with a different sub-index is a miss.
    send_word(make_word(CMD_READ, 16'h1000, 8'h02, 32'h0, ACC_RO, 16'h0000));
    send_word(make_word(CMD_NONE, 16'h0000, 8'h00, 32'h0, ACC_RO, 16'h0000));
    drain();

    // Random part. The table fills up along the way, after which every load is refused.
    // A stretch in the middle runs with no idling on either side, and later the sender
    // waits once more for the block to empty.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      quiet = (n >= 300 && n < 500);
      if (n == 600) drain();
      send_word(random_word());
    end
    quiet = 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d request words, %0d of them loads (%0d refused on a full table).",
             words_sent, loads_sent, loads_refused);
    $display("Compared %0d responses against the predicted table contents.", replies_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
